/* design/pts_pkg.sv */
package pts_pkg;

   // Field widths fixed by the item format
   localparam int IDX_W  = 4;
   localparam int PRIO_W = 8;
   localparam int CNT_W  = IDX_W + 1;

   // Highest table depth that a 4-bit index can reach
   localparam int ADDRESSABLE          = 1 << IDX_W;
   localparam int THREAD_COUNT_DEFAULT = 16;
   localparam logic [IDX_W-1:0] IDLE_RESET = IDX_W'(15);

   // Packed port widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   // Operation codes carried in req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_ELECT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic write_entry;
      logic load_elect;
      logic scan_step;
      logic finish;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic scan_empty;
      logic scan_last;
      logic out_free;
   } status_type;

endpackage

/* design/priority_thread_selector_core.sv */
// Write transaction: table entry updated at acceptance.
// Elect transaction: accept, ST_SCAN visits each entry of the range in turn (an
// empty range passes through ST_SCAN without a step), then ST_DONE delivers the
// result once the result register is free. A new request is accepted only in
// ST_IDLE, after delivery; the scan of the thread table visits one entry per cycle.
// Reset: synchronous; clears the table and loads idle index 15.
module priority_thread_selector_core #(
   parameter int THREAD_COUNT = pts_pkg::THREAD_COUNT_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata, low bit up: entry_index[3:0], entry_priority[11:4],
   // entry_runnable[12], entry_has_budget[13], range_low[17:14],
   // range_high[21:18], previous_thread[25:22], running_thread[29:26], zeros
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pts_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,   // op
   // rsp_tdata, low bit up: chosen_thread[3:0], zeros
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,   // found
   input  logic                           csr_we,
   input  logic [pts_pkg::IDX_W-1:0]      csr_wdata    // idle_thread_index
);

   pts_pkg::cmd_type    cmd;
   pts_pkg::status_type status;

   pts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pts_datapath #(
      .THREAD_COUNT (THREAD_COUNT)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* design/pts_ctrl.sv */
module pts_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_op,
   output logic                req_tready,
   input  pts_pkg::status_type status,
   output pts_pkg::cmd_type    cmd
);

   pts_pkg::state_type state_ff, state_in;
   logic               accept;

   assign req_tready = (state_ff == pts_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Sequence one transaction: write at once, or scan then deliver
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         pts_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == pts_pkg::OP_ELECT) begin
                  cmd.load_elect = 1'b1;
                  state_in       = pts_pkg::ST_SCAN;
               end else begin
                  cmd.write_entry = 1'b1;
               end
            end
         end
         pts_pkg::ST_SCAN: begin
            if (status.scan_empty) begin
               state_in = pts_pkg::ST_DONE;
            end else begin
               cmd.scan_step = 1'b1;
               if (status.scan_last) begin
                  state_in = pts_pkg::ST_DONE;
               end
            end
         end
         pts_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = pts_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/pts_datapath.sv */
module pts_datapath #(
   parameter int THREAD_COUNT = pts_pkg::THREAD_COUNT_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [pts_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               csr_we,
   input  logic [pts_pkg::IDX_W-1:0]          csr_wdata,
   input  pts_pkg::cmd_type                   cmd,
   output pts_pkg::status_type                status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pts_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);

   // Only entries a 4-bit index can reach are stored
   localparam int DEPTH = (THREAD_COUNT < pts_pkg::ADDRESSABLE) ?
                          THREAD_COUNT : pts_pkg::ADDRESSABLE;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [pts_pkg::CNT_W-1:0] DEPTH_L = pts_pkg::CNT_W'(DEPTH);

   localparam int IW = pts_pkg::IDX_W;
   localparam int PW = pts_pkg::PRIO_W;
   localparam int CW = pts_pkg::CNT_W;

   // Unpack request fields
   logic [IW-1:0] f_index, f_low, f_high, f_prev, f_run;
   logic [PW-1:0] f_prio;
   logic          f_runnable, f_budget;

   assign f_index    = req_tdata[3:0];
   assign f_prio     = req_tdata[11:4];
   assign f_runnable = req_tdata[12];
   assign f_budget   = req_tdata[13];
   assign f_low      = req_tdata[17:14];
   assign f_high     = req_tdata[21:18];
   assign f_prev     = req_tdata[25:22];
   assign f_run      = req_tdata[29:26];

   // Thread table and configuration
   logic [PW-1:0] prio_ff [DEPTH];
   logic          runnable_ff [DEPTH];
   logic          budget_ff [DEPTH];
   logic [IW-1:0] idle_ff;

   // Scan state
   logic [IW-1:0] low_ff, low_in;
   logic [IW-1:0] high_ff, high_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic          inside_ff, inside_in;
   logic          have_ff, have_in;
   logic [PW-1:0] best_ff, best_in;
   logic [IW-1:0] chosen_ff, chosen_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0] rsp_chosen_ff;
   logic          rsp_found_ff;

   logic          write_ok;
   logic          cur_ok;
   logic          cur_qual;
   logic [PW-1:0] cur_prio;
   logic [IW-1:0] start;
   logic          start_inside;
   logic          keep_step;
   logic          take;

   assign write_ok = ({1'b0, f_index} < DEPTH_L);
   assign cur_ok   = ({1'b0, cur_ff} < DEPTH_L);
   assign cur_qual = cur_ok && runnable_ff[cur_ff[AW-1:0]] && budget_ff[cur_ff[AW-1:0]];
   assign cur_prio = cur_ok ? prio_ff[cur_ff[AW-1:0]] : '0;

   assign start        = (f_run == idle_ff) ? f_prev : f_run;
   assign start_inside = (start >= f_low) && (start <= f_high);

   // Last visit of an inside scan lands on the start thread, which wins ties
   assign keep_step = inside_ff && (rem_ff == CW'(1));
   assign take      = cur_qual && (!have_ff || (cur_prio > best_ff) ||
                                   (keep_step && (cur_prio >= best_ff)));

   // Scan bookkeeping
   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      cur_in    = cur_ff;
      rem_in    = rem_ff;
      inside_in = inside_ff;
      have_in   = have_ff;
      best_in   = best_ff;
      chosen_in = chosen_ff;
      if (cmd.load_elect) begin
         low_in    = f_low;
         high_in   = f_high;
         inside_in = start_inside;
         if (start_inside) begin
            cur_in = (start == f_high) ? f_low : start + IW'(1);
         end else begin
            cur_in = f_low;
         end
         rem_in    = (f_low <= f_high) ?
                     ({1'b0, f_high} - {1'b0, f_low} + CW'(1)) : '0;
         have_in   = 1'b0;
         best_in   = '0;
         chosen_in = idle_ff;
      end else if (cmd.scan_step) begin
         if (take) begin
            have_in   = 1'b1;
            best_in   = cur_prio;
            chosen_in = cur_ff;
         end
         cur_in = (cur_ff == high_ff) ? low_ff : cur_ff + IW'(1);
         rem_in = rem_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      low_ff    <= low_in;
      high_ff   <= high_in;
      cur_ff    <= cur_in;
      inside_ff <= inside_in;
      have_ff   <= have_in;
      best_ff   <= best_in;
      chosen_ff <= chosen_in;
      if (reset) begin
         rem_ff <= '0;
      end else begin
         rem_ff <= rem_in;
      end
   end

   // Table writes and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            prio_ff[i]     <= '0;
            runnable_ff[i] <= 1'b0;
            budget_ff[i]   <= 1'b0;
         end
         idle_ff <= pts_pkg::IDLE_RESET;
      end else begin
         if (cmd.write_entry && write_ok) begin
            prio_ff[f_index[AW-1:0]]     <= f_prio;
            runnable_ff[f_index[AW-1:0]] <= f_runnable;
            budget_ff[f_index[AW-1:0]]   <= f_budget;
         end
         if (csr_we) begin
            idle_ff <= csr_wdata;
         end
      end
   end

   // Hold the result until the transaction is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.finish) begin
         rsp_chosen_ff <= chosen_ff;
         rsp_found_ff  <= have_ff;
      end
   end

   assign status.scan_empty = (rem_ff == '0);
   assign status.scan_last  = (rem_ff == CW'(1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(pts_pkg::RSP_DATA_W - IW)'(0), rsp_chosen_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

/* tb/priority_thread_selector_core_tb.sv */
`timescale 1ns / 100ps

module priority_thread_selector_core_tb;

   localparam int THREADS      = 16;
   localparam int SETTLE       = 24;      // covers the longest elect, a 16-entry scan, plus margin
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 75;
   localparam int REPORT_LIMIT = 10;

   // Request fields, lowest bit last in the list below
   typedef struct packed {
      logic [1:0]                 pad;
      logic [pts_pkg::IDX_W-1:0]  running;
      logic [pts_pkg::IDX_W-1:0]  previous;
      logic [pts_pkg::IDX_W-1:0]  range_high;
      logic [pts_pkg::IDX_W-1:0]  range_low;
      logic                       has_budget;
      logic                       runnable;
      logic [pts_pkg::PRIO_W-1:0] entry_prio;
      logic [pts_pkg::IDX_W-1:0]  entry_index;
   } thread_req_type;

   typedef struct {
      logic [pts_pkg::IDX_W-1:0] chosen;
      logic                      found;
   } election_type;

   // Thread table mirror and the elections still owed by the block
   class election_scoreboard;
      logic [pts_pkg::PRIO_W-1:0] prio_table[THREADS];
      bit                         runnable_flag[THREADS];
      bit                         budget_flag[THREADS];
      logic [pts_pkg::IDX_W-1:0]  idle_idx;
      election_type               owed_elections[$];
      int                         mismatches;

      function new();
         for (int i = 0; i < THREADS; i++) begin
            prio_table[i]    = '0;
            runnable_flag[i] = 1'b0;
            budget_flag[i]   = 1'b0;
         end
         idle_idx   = pts_pkg::IDLE_RESET;
         mismatches = 0;
      endfunction

      function void set_idle(logic [pts_pkg::IDX_W-1:0] v);
         idle_idx = v;
      endfunction

      function bit ready_to_run(int idx);
         return idx < THREADS && runnable_flag[idx] && budget_flag[idx];
      endfunction

      // Fixed priority pick with circular tie-break after the start thread
      function election_type elect_thread(thread_req_type r);
         election_type res;
         int           lo, hi, n, start, idx, best, k;
         bit           in_range;
         res.chosen = idle_idx;
         res.found  = 1'b0;
         best  = 0;
         lo    = int'(r.range_low);
         hi    = int'(r.range_high);
         start = (r.running == idle_idx) ? int'(r.previous) : int'(r.running);
         if (lo <= hi) begin
            n        = hi - lo + 1;
            in_range = start >= lo && start <= hi;
            for (k = 1; k <= n; k++) begin
               if (in_range) begin
                  idx = start + k;
                  if (idx > hi) idx -= n;
               end else begin
                  idx = lo + k - 1;
               end
               if (ready_to_run(idx) && (!res.found || prio_table[idx] > best)) begin
                  res.found  = 1'b1;
                  best       = int'(prio_table[idx]);
                  res.chosen = idx[pts_pkg::IDX_W-1:0];
               end
            end
            // Start thread holds its slot on a tie
            if (res.found && in_range && ready_to_run(start) && prio_table[start] >= best)
               res.chosen = start[pts_pkg::IDX_W-1:0];
         end
         return res;
      endfunction

      function void note_request(logic op, thread_req_type r);
         if (op == pts_pkg::OP_WRITE) begin
            if (r.entry_index < THREADS) begin
               prio_table[r.entry_index]    = r.entry_prio;
               runnable_flag[r.entry_index] = r.runnable;
               budget_flag[r.entry_index]   = r.has_budget;
            end
         end else begin
            owed_elections.push_back(elect_thread(r));
         end
      endfunction

      function void check_response(logic [pts_pkg::RSP_DATA_W-1:0] tdata, logic tuser);
         election_type exp;
         if (owed_elections.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected result chosen=%0d found=%0b",
                        $realtime, tdata[pts_pkg::IDX_W-1:0], tuser);
            return;
         end
         exp = owed_elections.pop_front();
         if (tdata[pts_pkg::IDX_W-1:0] !== exp.chosen || tuser !== exp.found) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"%0t: result mismatch: expected chosen=%0d found=%0b, ",
                         "got chosen=%0d found=%0b"},
                        $realtime, exp.chosen, exp.found,
                        tdata[pts_pkg::IDX_W-1:0], tuser);
         end
      endfunction

      function int pending();
         return owed_elections.size();
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [pts_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [pts_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_we;
   logic [pts_pkg::IDX_W-1:0]      csr_wdata;

   election_scoreboard sb;
   bit                 sender_quiet;
   bit                 receiver_quiet;
   int                 rsp_hold;
   int                 cycle_count;

   priority_thread_selector_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run if it stalls
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   // Sample every handshake and register write at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, thread_req_type'(req_tdata));
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser);
         if (csr_we)
            sb.set_idle(csr_wdata);
      end
   end

   // Result side: random stall per transaction, long hold-off on request
   initial begin : result_sink
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_tready = 1'b0;
            while (rsp_hold > 0) begin
               @(negedge clock);
               rsp_hold--;
            end
         end
         stall = receiver_quiet ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock);
         while (!(rsp_tvalid && rsp_tready) && rsp_hold == 0);
         @(negedge clock);
      end
   end

   // Offer one transaction after a random gap; return at the falling edge after acceptance
   task automatic send_request(input logic op, input thread_req_type r);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = r;
      do @(posedge clock);
      while (!req_tready);
      @(negedge clock);
   endtask

   function automatic thread_req_type random_fields();
      thread_req_type r;
      r     = thread_req_type'($urandom);
      r.pad = '0;
      return r;
   endfunction

   task automatic write_entry(input int idx, input int prio, input bit run, input bit bud);
      thread_req_type r;
      r             = random_fields();
      r.entry_index = (pts_pkg::IDX_W)'(idx);
      r.entry_prio  = (pts_pkg::PRIO_W)'(prio);
      r.runnable    = run;
      r.has_budget  = bud;
      send_request(pts_pkg::OP_WRITE, r);
   endtask

   task automatic elect(input int lo, input int hi, input int prev, input int running);
      thread_req_type r;
      r            = random_fields();
      r.range_low  = (pts_pkg::IDX_W)'(lo);
      r.range_high = (pts_pkg::IDX_W)'(hi);
      r.previous   = (pts_pkg::IDX_W)'(prev);
      r.running    = (pts_pkg::IDX_W)'(running);
      send_request(pts_pkg::OP_ELECT, r);
   endtask

   // Hold the sender until every election is back and the block has gone quiet
   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_idle_index(input logic [pts_pkg::IDX_W-1:0] v);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Random mix of elections and table writes, writes biased toward eligible threads and narrow priorities
   task automatic random_item();
      thread_req_type            r;
      logic [pts_pkg::IDX_W-1:0] swap;
      r = random_fields();
      if ($urandom_range(0, 99) < 40) begin
         if ($urandom_range(0, 3) != 0) begin
            r.runnable   = 1'b1;
            r.has_budget = 1'b1;
         end
         if ($urandom_range(0, 1) != 0)
            r.entry_prio = (pts_pkg::PRIO_W)'($urandom_range(0, 7));
         send_request(pts_pkg::OP_WRITE, r);
      end else begin
         if (r.range_low > r.range_high && $urandom_range(0, 99) < 85) begin
            swap         = r.range_low;
            r.range_low  = r.range_high;
            r.range_high = swap;
         end
         if ($urandom_range(0, 3) == 0) r.running = sb.idle_idx;
         send_request(pts_pkg::OP_ELECT, r);
      end
   endtask

   initial begin : stimulus
      logic [pts_pkg::IDX_W-1:0] idle_choice[6];
      sb             = new();
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = pts_pkg::OP_WRITE;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      rsp_hold       = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty table, priority extremes, ties, wrap, empty and single ranges
      elect(0, 15, 3, 5);
      write_entry(0, 255, 1, 1);
      write_entry(15, 0, 1, 1);
      write_entry(5, 200, 1, 0);
      write_entry(6, 200, 0, 1);
      write_entry(7, 100, 1, 1);
      write_entry(9, 100, 1, 1);
      elect(0, 15, 0, 8);
      elect(1, 15, 0, 7);
      elect(1, 14, 0, 15);
      elect(8, 3, 2, 4);
      elect(6, 6, 0, 6);
      elect(7, 7, 0, 7);
      elect(10, 12, 0, 11);
      write_entry(9, 255, 1, 1);
      elect(0, 15, 0, 0);
      elect(0, 15, 15, 9);
      write_entry(0, 0, 0, 0);
      elect(0, 15, 3, 15);
      elect(15, 15, 0, 15);
      elect(4, 8, 1, 12);
      drain();

      // Random phases, each under its own idle index
      idle_choice[0] = 4'd0;
      idle_choice[1] = 4'd15;
      idle_choice[2] = 4'd6;
      idle_choice[3] = (pts_pkg::IDX_W)'($urandom_range(0, 15));
      idle_choice[4] = 4'd3;
      idle_choice[5] = 4'd15;
      for (int p = 0; p < 6; p++) begin
         write_idle_index(idle_choice[p]);
         sender_quiet   = (p == 2);
         receiver_quiet = (p == 2);
         if (p == 3) begin
            // Back up the result side while requests keep coming
            rsp_hold     = 250;
            sender_quiet = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 3 && i == 40) sender_quiet = 1'b0;
            random_item();
         end
         drain();
      end

      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
